// ----- hw/rtl/internet_checksum_stream_assert.svh -----
// Assertion macros shared by the checksum stream RTL.
// Expects signals clk and rst_n in the scope of use.
`ifndef INTERNET_CHECKSUM_STREAM_ASSERT_SVH
`define INTERNET_CHECKSUM_STREAM_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define ICS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ICS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/ics_pkg.sv -----
// Package for the checksum stream: types, mode codes and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ics_pkg;

    typedef enum logic [1:0] {
        FUNC_IP  = 2'd0,
        FUNC_UDP = 2'd1,
        FUNC_TCP = 2'd2
    } ics_func_t;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [31:0] PROTO_UDP         = 32'd17;
    localparam logic [31:0] PROTO_TCP         = 32'd6;
    localparam logic [31:0] PSEUDO_LEN_OFFSET = 32'd8;

    // protocol number minus length offset folded into one constant: count + K
    localparam logic [31:0] TERM_UDP = PROTO_UDP - PSEUDO_LEN_OFFSET;
    localparam logic [31:0] TERM_TCP = PROTO_TCP - PSEUDO_LEN_OFFSET;

    typedef struct packed {
        logic [31:0] sum;
        logic [15:0] count;
        logic [1:0]  func;
    } ics_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ics_qstat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/internet_checksum_stream.sv -----
// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------------
// input    | in_valid / in_stall | data_byte[7:0] func[1:0] last_byte
// output   | out_valid/out_stall | checksum_value[15:0]
//
// One byte per cycle unless stalled; a sum crosses queue, s1, s2 and output regs.
// The front end's single 32-bit add per byte sets the input rate.
// in_stall rises only when the region queue is full behind a stalled output.
// Reset (rst_n low, asynchronous) clears the running sum, count and all valids.
// Depends on ics_pkg, ics_front, ics_queue and ics_back.
`timescale 1ns / 1ps
`default_nettype none

module internet_checksum_stream #(
    parameter int unsigned QUEUE_DEPTH = ics_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic [1:0]  func,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      checksum_value
);

    logic                push;
    logic                pop;
    ics_pkg::ics_entry_t push_entry;
    ics_pkg::ics_entry_t head_entry;
    ics_pkg::ics_qstat_t qstat;

    ics_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .func       (func),
        .last_byte  (last_byte),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    ics_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .qstat      (qstat)
    );

    ics_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_entry     (head_entry),
        .qstat          (qstat),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .checksum_value (checksum_value)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ics_front.sv -----
// Front end: accepts bytes, pairs them into words and keeps the running sum.
// Depends on ics_pkg; pushes one entry per region into ics_queue.
`timescale 1ns / 1ps
`default_nettype none

module ics_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic [1:0]         func,
    input  wire logic               last_byte,
    input  wire ics_pkg::ics_qstat_t qstat,
    output logic                    push,
    output ics_pkg::ics_entry_t     push_entry
);

    logic [31:0] acc_reg,   acc_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  held_reg,  held_next;
    logic        odd_reg,   odd_next;

    logic        accept;
    logic [15:0] word;
    logic [31:0] acc_sum;
    logic [15:0] count_inc;

    assign in_stall  = qstat.full;
    assign accept    = in_valid && !in_stall;
    assign word      = odd_reg ? {held_reg, data_byte} : {data_byte, 8'h00};
    assign acc_sum   = acc_reg + {16'h0000, word};
    assign count_inc = count_reg + 16'd1;

    assign push             = accept && last_byte;
    assign push_entry.sum   = acc_sum;
    assign push_entry.count = count_inc;
    assign push_entry.func  = func;

    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        held_next  = held_reg;
        odd_next   = odd_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                acc_next   = '0;
                count_next = '0;
                held_next  = '0;
                odd_next   = 1'b0;
            end
            else
            begin
                count_next = count_inc;
                if (odd_reg)
                begin
                    acc_next  = acc_sum;
                    held_next = '0;
                    odd_next  = 1'b0;
                end
                else
                begin
                    held_next = data_byte;
                    odd_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            held_reg  <= '0;
            odd_reg   <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            odd_reg   <= odd_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ics_queue.sv -----
// Short queue of finished region sums between front and back end.
// Depends on ics_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module ics_queue #(
    parameter int unsigned DEPTH = ics_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ics_pkg::ics_entry_t push_entry,
    input  wire logic                pop,
    output ics_pkg::ics_entry_t      head_entry,
    output ics_pkg::ics_qstat_t      qstat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ics_pkg::ics_entry_t slots_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_entry  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

`include "internet_checksum_stream_assert.svh"

    `ICS_ASSERT_NEVER(a_push_full, push && qstat.full && !pop, "queue push while full")
    `ICS_ASSERT_NEVER(a_pop_empty, pop && qstat.empty, "queue pop while empty")
    `ICS_ASSERT(a_count_up, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1),
        "queue count did not advance on push")

endmodule

`default_nettype wire

// ----- hw/rtl/ics_back.sv -----
// Back end: adds the pseudo-header terms, folds carries and inverts.
// Depends on ics_pkg and the assertion macro header; drains ics_queue.
`timescale 1ns / 1ps
`default_nettype none

module ics_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ics_pkg::ics_entry_t head_entry,
    input  wire ics_pkg::ics_qstat_t qstat,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [15:0]              checksum_value
);

    logic        s1_valid_reg;
    logic [31:0] s1_sum_reg;
    logic [31:0] s1_term_reg;
    logic        s2_valid_reg;
    logic [31:0] s2_total_reg;
    logic        out_valid_reg;
    logic [15:0] checksum_reg;

    logic        out_ready;
    logic        s2_ready;
    logic        s1_ready;
    logic [31:0] term;
    logic [16:0] fold1;
    logic [15:0] fold2;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop       = !qstat.empty && s1_ready;

    always_comb
    begin
        case (ics_pkg::ics_func_t'(head_entry.func))
            ics_pkg::FUNC_UDP: term = {16'h0000, head_entry.count} + ics_pkg::TERM_UDP;
            ics_pkg::FUNC_TCP: term = {16'h0000, head_entry.count} + ics_pkg::TERM_TCP;
            default:           term = '0;
        endcase
    end

    assign fold1 = {1'b0, s2_total_reg[31:16]} + {1'b0, s2_total_reg[15:0]};
    assign fold2 = fold1[15:0] + {15'h0000, fold1[16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= !qstat.empty;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_sum_reg  <= head_entry.sum;
            s1_term_reg <= term;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_total_reg <= s1_sum_reg + s1_term_reg;
        end
        if (out_ready && s2_valid_reg)
        begin
            checksum_reg <= ~fold2;
        end
    end

    assign out_valid      = out_valid_reg;
    assign checksum_value = checksum_reg;

`include "internet_checksum_stream_assert.svh"

    `ICS_ASSERT(a_s2_hold, (s2_valid_reg && !out_ready) |=> s2_valid_reg,
        "stage 2 request lost under stall")

endmodule

`default_nettype wire
